// ===== sv/ctpd_pkg.sv =====
// Shared types, register codes, colour conversion and index swap for the colour-table decoder.
`default_nettype none

package ctpd_pkg;

  localparam logic [1:0] REG_PIXEL_FORMAT     = 2'd0;
  localparam logic [1:0] REG_CLUT_FORMAT      = 2'd1;
  localparam logic [1:0] REG_INDEX_SWAP       = 2'd2;
  localparam logic [1:0] REG_CLUT_ENTRY_COUNT = 2'd3;

  localparam logic [2:0] PF_4BIT  = 3'd0;
  localparam logic [2:0] PF_8BIT  = 3'd1;
  localparam logic [2:0] PF_16BIT = 3'd2;
  localparam logic [2:0] PF_24BIT = 3'd3;
  localparam logic [2:0] PF_32BIT = 3'd4;

  localparam logic [1:0] CF_NONE = 2'd0;

  localparam logic [2:0] NB_TWO   = 3'd2;
  localparam logic [2:0] NB_THREE = 3'd3;

  localparam logic [2:0] PIXEL_FORMAT_RESET = PF_8BIT;
  localparam logic [1:0] CLUT_FORMAT_RESET  = CF_NONE;

  localparam logic [31:0] RGBA_BLACK = 32'hFF00_0000;

  typedef struct packed {
    logic        use_ram;
    logic [31:0] rgba;
  } lane_t;

  function automatic logic [31:0] to_rgba(input logic [31:0] w, input logic [2:0] nbytes);
    logic [31:0] res;
    case (nbytes)
      NB_TWO: begin
        res = {(w[15] ? 8'hFF : 8'h00), w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
      end
      NB_THREE: begin
        res = {8'hFF, w[23:0]};
      end
      default: begin
        res = {(w[31] ? 8'hFF : {w[30:24], 1'b0}), w[23:0]};
      end
    endcase
    return res;
  endfunction

  function automatic logic [7:0] swap_index_bits(input logic [7:0] idx);
    return {idx[7:5], idx[3], idx[4], idx[2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/ctpd_if.sv =====
// Valid/ready channel interfaces for the input bytes and the decoded pixels.
`default_nettype none

interface ctpd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, action, data_byte, restart, input ready);
  modport sink (input valid, action, data_byte, restart, output ready);
endinterface

interface ctpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_of_run;

  modport source (output valid, red, green, blue, alpha, last_of_run, input ready);
  modport sink (input valid, red, green, blue, alpha, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/clut_texture_pixel_decoder_top.sv =====
// Top level of the colour-table texture decoder: byte gathering, palette store and pixel output.
// The block takes one stream byte per cycle while the output is not stalled. Table bytes are
// gathered into 16-, 24- or 32-bit entries, converted to RGBA and written to the palette RAM in
// the cycle the byte is taken; indexed pixel bytes read the palette through two read ports at
// once, so a 4-bit byte looks up both nibbles together. Results pass the palette read register,
// then the output register. The output port moves one pixel per cycle while ready is high, so
// 4-bit pixel bytes, which give two pixels each, are taken at a lower rate; all other bytes
// sustain one per cycle. The palette needs no clearing after reset: an entry below the
// configured count that was never written reads as an undefined colour.
`default_nettype none

module clut_texture_pixel_decoder_top
  import ctpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  ctpd_in_if.sink         byte_in,
  ctpd_out_if.source      pixel_out
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [2:0]  pixel_format;
  logic [1:0]  clut_format;
  logic        index_swap;
  logic [8:0]  clut_entry_count;

  logic [8:0]  entry_counter, entry_counter_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [23:0] byte_gather, byte_gather_next;

  logic        s1_valid, s1_two;
  lane_t       s1_lane [2];
  logic        o_valid, o_two, o_sel;
  logic [31:0] o_rgba [2];

  logic [8:0]  limit;
  logic        accept, s1_adv, o_done;
  logic [1:0]  ph0;
  logic [23:0] ga0;
  logic [8:0]  cnt0;
  logic        table_active, direct, complete, gather_en, s1_load, ram_we;
  logic [2:0]  nbytes;
  logic [31:0] word;
  logic [7:0]  idx [2];
  logic [7:0]  entry [2];
  lane_t       lane [2];
  logic [31:0] rdata [2];
  logic [31:0] sel_rgba;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format     <= PIXEL_FORMAT_RESET;
      clut_format      <= CLUT_FORMAT_RESET;
      index_swap       <= 1'b0;
      clut_entry_count <= 9'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIXEL_FORMAT:     pixel_format     <= cfg_data[2:0];
        REG_CLUT_FORMAT:      clut_format      <= cfg_data[1:0];
        REG_INDEX_SWAP:       index_swap       <= cfg_data[0];
        REG_CLUT_ENTRY_COUNT: clut_entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limit = (clut_entry_count < 9'(PALETTE_DEPTH)) ? clut_entry_count : 9'(PALETTE_DEPTH);

  assign o_done  = o_valid & pixel_out.ready & (~o_two | o_sel);
  assign s1_adv  = s1_valid & (~o_valid | o_done);
  assign byte_in.ready = ~s1_valid | s1_adv;
  assign accept  = byte_in.valid & byte_in.ready;

  assign ph0  = byte_in.restart ? 2'd0 : byte_phase;
  assign ga0  = byte_in.restart ? 24'd0 : byte_gather;
  assign cnt0 = byte_in.restart ? 9'd0 : entry_counter;

  assign table_active = ~byte_in.action & (clut_format != CF_NONE) & (cnt0 < limit);
  assign direct = byte_in.action &
                  ((pixel_format == PF_16BIT) | (pixel_format == PF_24BIT) |
                   (pixel_format == PF_32BIT));
  assign nbytes    = byte_in.action ? pixel_format : ({1'b0, clut_format} + 3'd1);
  assign complete  = ({1'b0, ph0} + 3'd1) >= nbytes;
  assign word      = {8'd0, ga0} | ({24'd0, byte_in.data_byte} << {ph0, 3'b000});
  assign gather_en = table_active | direct;
  assign ram_we    = accept & table_active & complete;

  always_comb begin
    byte_phase_next    = ph0;
    byte_gather_next   = ga0;
    entry_counter_next = cnt0;
    if (gather_en) begin
      if (complete) begin
        byte_phase_next  = 2'd0;
        byte_gather_next = 24'd0;
      end else begin
        byte_phase_next  = ph0 + 2'd1;
        byte_gather_next = word[23:0];
      end
    end
    if (table_active & complete) begin
      entry_counter_next = cnt0 + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 2'd0;
      byte_gather   <= 24'd0;
      entry_counter <= 9'd0;
    end else if (accept) begin
      byte_phase    <= byte_phase_next;
      byte_gather   <= byte_gather_next;
      entry_counter <= entry_counter_next;
    end
  end

  assign idx[0] = (pixel_format == PF_4BIT) ? {4'd0, byte_in.data_byte[3:0]} : byte_in.data_byte;
  assign idx[1] = {4'd0, byte_in.data_byte[7:4]};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      entry[l] = index_swap ? swap_index_bits(idx[l]) : idx[l];
      if (clut_format == CF_NONE) begin
        lane[l].use_ram = 1'b0;
        if (pixel_format == PF_4BIT) begin
          lane[l].rgba = {8'hFF, {3{idx[l][3:0], idx[l][3:0]}}};
        end else begin
          lane[l].rgba = {8'hFF, {3{idx[l]}}};
        end
      end else if ({1'b0, entry[l]} >= limit) begin
        lane[l].use_ram = 1'b0;
        lane[l].rgba    = RGBA_BLACK;
      end else begin
        lane[l].use_ram = 1'b1;
        lane[l].rgba    = RGBA_BLACK;
      end
    end
    if (direct) begin
      lane[0].use_ram = 1'b0;
      lane[0].rgba    = to_rgba(word, pixel_format);
    end
  end

  assign s1_load = accept & byte_in.action &
                   ((pixel_format == PF_4BIT) | (pixel_format == PF_8BIT) | (direct & complete));

  ctpd_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (cnt0[AW-1:0] & AW'(PALETTE_DEPTH - 1)),
    .wdata   (to_rgba(word, nbytes)),
    .re_a    (s1_load),
    .raddr_a (entry[0][AW-1:0]),
    .rdata_a (rdata[0]),
    .re_b    (s1_load),
    .raddr_b (entry[1][AW-1:0]),
    .rdata_b (rdata[1])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_two     <= (pixel_format == PF_4BIT);
      s1_lane[0] <= lane[0];
      s1_lane[1] <= lane[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_sel   <= 1'b0;
    end else if (~o_valid | o_done) begin
      o_valid <= s1_valid;
      o_sel   <= 1'b0;
    end else if (pixel_out.ready) begin
      o_sel   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_two    <= s1_two;
      o_rgba[0] <= s1_lane[0].use_ram ? rdata[0] : s1_lane[0].rgba;
      o_rgba[1] <= s1_lane[1].use_ram ? rdata[1] : s1_lane[1].rgba;
    end
  end

  assign sel_rgba              = o_sel ? o_rgba[1] : o_rgba[0];
  assign pixel_out.valid       = o_valid;
  assign pixel_out.red         = sel_rgba[7:0];
  assign pixel_out.green       = sel_rgba[15:8];
  assign pixel_out.blue        = sel_rgba[23:16];
  assign pixel_out.alpha       = sel_rgba[31:24];
  assign pixel_out.last_of_run = ~o_two | o_sel;

endmodule

`default_nettype wire

// ===== sv/ctpd_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module ctpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== sim/clut_texture_pixel_decoder_top_tb.sv =====
// Self-checking testbench for the colour-table texture decoder: directed and random byte streams.
module clut_texture_pixel_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctpd_pkg::*;

  localparam int PALETTE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic ACT_TABLE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;
  localparam logic [1:0] CF_16BIT = 2'd1;
  localparam logic [2:0] PF_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_run;
  } pixel_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  ctpd_in_if  in_ch ();
  ctpd_out_if out_ch ();

  clut_texture_pixel_decoder_top #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .byte_in(in_ch),
    .pixel_out(out_ch)
  );

  // Shadow copy of the decoder state and registers.
  logic [31:0] pal_mem [PALETTE_DEPTH];
  bit          pal_valid [PALETTE_DEPTH];
  logic [8:0]  ent_cnt = '0;
  logic [1:0]  byte_ph = '0;
  logic [23:0] byte_acc = '0;
  logic [2:0]  reg_pf = PIXEL_FORMAT_RESET;
  logic [1:0]  reg_cf = CLUT_FORMAT_RESET;
  logic        reg_swap = 1'b0;
  logic [8:0]  reg_count = '0;

  pixel_t pending_pixels[$];
  pixel_t want;
  int     fail_count = 0;
  int     stream_items = 0;
  int     cycle_count = 0;
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_count();
    return (reg_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(reg_count);
  endfunction

  function automatic logic [7:0] palette_index(logic [7:0] idx);
    return (reg_swap && (idx[3] != idx[4])) ? idx ^ 8'h18 : idx;
  endfunction

  function automatic bit unwritten_entry(logic [7:0] idx);
    logic [7:0] ent;
    ent = palette_index(idx);
    return (ent < eff_count()) && !pal_valid[ent];
  endfunction

  function automatic bit hits_unwritten(logic act, logic [7:0] b);
    if (act != ACT_PIXEL || reg_cf == CF_NONE) return 1'b0;
    if (reg_pf == PF_4BIT) begin
      return unwritten_entry({4'd0, b[3:0]}) || unwritten_entry({4'd0, b[7:4]});
    end
    if (reg_pf == PF_8BIT) return unwritten_entry(b);
    return 1'b0;
  endfunction

  function automatic logic [31:0] rgba_from_word(logic [31:0] w, int nbytes);
    logic [7:0] r, g, bl, a;
    if (nbytes == 2) begin
      r = {w[4:0], 3'b000};
      g = {w[9:5], 3'b000};
      bl = {w[14:10], 3'b000};
      a = w[15] ? 8'hFF : 8'h00;
    end else begin
      r = w[7:0];
      g = w[15:8];
      bl = w[23:16];
      if (nbytes == 3) a = 8'hFF;
      else if (w[31:24] >= 8'h80) a = 8'hFF;
      else a = {w[30:24], 1'b0};
    end
    return {a, bl, g, r};
  endfunction

  function automatic logic [31:0] lookup_colour(logic [7:0] idx, bit four_bit);
    logic [7:0] grey, ent;
    if (reg_cf == CF_NONE) begin
      grey = four_bit ? 8'(idx[3:0] * 17) : idx;
      return {8'hFF, grey, grey, grey};
    end
    ent = palette_index(idx);
    if (ent >= eff_count()) return RGBA_BLACK;
    return pal_mem[ent];
  endfunction

  function automatic bit gather_byte(logic [7:0] b, int nbytes, output logic [31:0] word);
    if (int'(byte_ph) + 1 >= nbytes) begin
      word = {8'h00, byte_acc} | (32'(b) << (8 * byte_ph));
      byte_ph = '0;
      byte_acc = '0;
      return 1'b1;
    end
    byte_acc = byte_acc | (24'(b) << (8 * byte_ph));
    byte_ph = byte_ph + 2'd1;
    return 1'b0;
  endfunction

  function automatic void push_pixel(logic [31:0] rgba, logic last_px);
    pixel_t px;
    px.red = rgba[7:0];
    px.green = rgba[15:8];
    px.blue = rgba[23:16];
    px.alpha = rgba[31:24];
    px.last_of_run = last_px;
    pending_pixels.push_back(px);
  endfunction

  function automatic void decode_byte(logic act, logic [7:0] b, logic rs, output bit ignored);
    logic [31:0] word;
    ignored = 1'b0;
    if (rs) begin
      byte_ph = '0;
      byte_acc = '0;
      ent_cnt = '0;
    end
    if (act == ACT_TABLE) begin
      if (reg_cf == CF_NONE || ent_cnt >= eff_count()) begin
        ignored = !rs;
      end else if (gather_byte(b, int'(reg_cf) + 1, word)) begin
        pal_mem[ent_cnt[7:0]] = rgba_from_word(word, int'(reg_cf) + 1);
        pal_valid[ent_cnt[7:0]] = 1'b1;
        ent_cnt = ent_cnt + 9'd1;
      end
    end else begin
      case (reg_pf)
        PF_4BIT: begin
          push_pixel(lookup_colour({4'd0, b[3:0]}, 1'b1), 1'b0);
          push_pixel(lookup_colour({4'd0, b[7:4]}, 1'b1), 1'b1);
        end
        PF_8BIT: begin
          push_pixel(lookup_colour(b, 1'b0), 1'b1);
        end
        PF_16BIT, PF_24BIT, PF_32BIT: begin
          if (gather_byte(b, int'(reg_pf), word)) begin
            push_pixel(rgba_from_word(word, int'(reg_pf)), 1'b1);
          end
        end
        default: begin
          ignored = !rs;
        end
      endcase
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %02h, got %02h", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with no pixel expected");
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("red", want.red, out_ch.red);
        check_field("green", want.green, out_ch.green);
        check_field("blue", want.blue, out_ch.blue);
        check_field("alpha", want.alpha, out_ch.alpha);
        check_field("last_of_run", 8'(want.last_of_run), 8'(out_ch.last_of_run));
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PIXEL_FORMAT: reg_pf = value[2:0];
      REG_CLUT_FORMAT: reg_cf = value[1:0];
      REG_INDEX_SWAP: reg_swap = value[0];
      REG_CLUT_ENTRY_COUNT: reg_count = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] pf, input logic [1:0] cf, input logic swap_en,
                            input logic [8:0] count);
    write_reg(REG_PIXEL_FORMAT, {6'd0, pf});
    write_reg(REG_CLUT_FORMAT, {7'd0, cf});
    write_reg(REG_INDEX_SWAP, {8'd0, swap_en});
    write_reg(REG_CLUT_ENTRY_COUNT, count);
  endtask

  task automatic send_byte(input logic act, input logic [7:0] b, input logic rs);
    bit ignored;
    if (hits_unwritten(act, b)) return;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.data_byte <= b;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(act, b, rs, ignored);
    if (!ignored) stream_items++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_grey_without_table();
    send_byte(ACT_PIXEL, 8'h00, 1'b0);
    send_byte(ACT_PIXEL, 8'hFF, 1'b0);
    send_byte(ACT_TABLE, 8'h5A, 1'b1);
    send_byte(ACT_PIXEL, 8'hA5, 1'b0);
    wait_idle();
    set_config(PF_4BIT, CF_NONE, 1'b0, 9'd0);
    send_byte(ACT_PIXEL, 8'hF0, 1'b0);
    wait_idle();
  endtask

  task automatic test_palette_lookup();
    set_config(PF_4BIT, CF_16BIT, 1'b0, 9'd3);
    send_byte(ACT_TABLE, 8'h00, 1'b1);
    send_byte(ACT_TABLE, 8'h00, 1'b0);
    send_byte(ACT_TABLE, 8'hFF, 1'b0);
    send_byte(ACT_TABLE, 8'hFF, 1'b0);
    send_byte(ACT_TABLE, 8'hE0, 1'b0);
    send_byte(ACT_TABLE, 8'h83, 1'b0);
    send_byte(ACT_TABLE, 8'h11, 1'b0);
    send_byte(ACT_PIXEL, 8'h10, 1'b0);
    send_byte(ACT_PIXEL, 8'h32, 1'b0);
    send_byte(ACT_PIXEL, 8'hFF, 1'b0);
    wait_idle();
    set_config(PF_8BIT, CF_16BIT, 1'b1, 9'd3);
    send_byte(ACT_PIXEL, 8'h02, 1'b0);
    send_byte(ACT_PIXEL, 8'h10, 1'b0);
    wait_idle();
  endtask

  task automatic test_direct_pixels();
    set_config(PF_16BIT, CF_NONE, 1'b0, 9'd0);
    send_byte(ACT_PIXEL, 8'hFF, 1'b1);
    send_byte(ACT_PIXEL, 8'h7F, 1'b0);
    wait_idle();
    set_config(PF_24BIT, CF_NONE, 1'b0, 9'd0);
    send_byte(ACT_PIXEL, 8'h01, 1'b0);
    send_byte(ACT_PIXEL, 8'h80, 1'b0);
    send_byte(ACT_PIXEL, 8'hFF, 1'b0);
    wait_idle();
    set_config(PF_32BIT, CF_NONE, 1'b0, 9'd0);
    send_byte(ACT_PIXEL, 8'hFF, 1'b0);
    send_byte(ACT_PIXEL, 8'h00, 1'b0);
    send_byte(ACT_PIXEL, 8'hFF, 1'b0);
    send_byte(ACT_PIXEL, 8'h80, 1'b0);
    wait_idle();
  endtask

  task automatic test_odd_settings();
    set_config(PF_UNUSED, CF_NONE, 1'b0, 9'd0);
    send_byte(ACT_PIXEL, 8'h42, 1'b0);
    wait_idle();
    // A table byte and a pixel byte end up in the same gathered word.
    set_config(PF_16BIT, CF_16BIT, 1'b0, 9'd1);
    send_byte(ACT_TABLE, 8'h34, 1'b1);
    send_byte(ACT_PIXEL, 8'h12, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_stream(input int src_pct, input int sink_pct, input int quota);
    int first, n, i, loads, pick;
    logic [8:0] count;
    logic [2:0] pf;
    logic [7:0] b;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    first = stream_items;
    while (stream_items - first < quota) begin
      pf = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      pick = $urandom_range(19);
      if (pick == 0) count = '0;
      else if (pick == 1) count = 9'(PALETTE_DEPTH);
      else if (pick == 2) count = 9'd511;
      else if (pick == 3) count = 9'($urandom_range(510, PALETTE_DEPTH + 1));
      else count = 9'($urandom_range(40, 1));
      set_config(pf, 2'($urandom_range(3)), 1'($urandom_range(1)), count);
      if (reg_cf != CF_NONE) begin
        loads = eff_count() * (int'(reg_cf) + 1);
        for (i = 0; i < loads; i++) send_byte(ACT_TABLE, 8'($urandom), i == 0);
      end
      n = $urandom_range(90, 30);
      for (i = 0; i < n; i++) begin
        b = ($urandom_range(7) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        send_byte(($urandom_range(99) < 85) ? ACT_PIXEL : ACT_TABLE, b,
                  $urandom_range(29) == 0);
      end
      wait_idle();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_TABLE;
    in_ch.data_byte <= '0;
    in_ch.restart <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_grey_without_table();
    test_palette_lookup();
    test_direct_pixels();
    test_odd_settings();
    test_random_stream(24, 69, 450);
    test_random_stream(69, 24, 450);
    test_random_stream(0, 0, 450);
    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
